@@ sv/enbq_pkg.sv @@
// shared types and constants for the bit-quad euler number unit
// no dependencies; imported by every module of the unit
`default_nettype none

package enbq_pkg;

    // frame size limits and derived widths
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // field widths
    localparam int PIXEL_W = 8;
    localparam int THR_W   = 8;
    localparam int SIZE_W  = 11;
    localparam int COUNT_W = 20;
    localparam int ACC_W   = 22;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic [THR_W-1:0]  RESET_THRESHOLD = 8'd127;
    localparam logic [SIZE_W-1:0] RESET_SIZE      = 11'd28;

    // window queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [SIZE_W-1:0] image_width;
        logic [SIZE_W-1:0] image_height;
    } cfg_t;

    typedef enum logic [1:0] {
        WIN_NONE   = 2'd0,
        WIN_SINGLE = 2'd1,
        WIN_TRIPLE = 2'd2,
        WIN_DIAG   = 2'd3
    } win_kind_t;

    typedef struct packed {
        win_kind_t kind;
        logic      last;
    } quad_item_t;

    // saturate a configured size into 2..hi and return the last index
    function automatic logic [SIZE_W-1:0] last_index(input logic [SIZE_W-1:0] v,
                                                      input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] s;
        if (v < SIZE_W'(2))
            s = SIZE_W'(2);
        else if (v > hi)
            s = hi;
        else
            s = v;
        return s - SIZE_W'(1);
    endfunction

endpackage

`default_nettype wire

@@ sv/euler_number_bit_quads_unit.sv @@
// euler number by bit-quad counting, one grayscale pixel per cycle while the queue has room
// the last pixel of a frame passes stage one, the window queue, then the result register
// 1 pixel per cycle with queue room, set by the single-port read-first line buffer
// reset: threshold 127, width and height 28, frame position and totals cleared;
// line buffer is not cleared and needs no clearing pass
// depends on enbq_pkg, enbq_front, enbq_queue, enbq_back
`default_nettype none

module euler_number_bit_quads_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [enbq_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [enbq_pkg::CFG_DATA_W-1:0]     cfg_data,
    // pixel stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [7:0]                          s_axis_tdata,   // pixel[7:0]
    // result stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // euler_number[19:0], single_count[39:20], triple_count[59:40], diagonal_count[79:60]
    output logic [79:0]                              m_axis_tdata
);
    import enbq_pkg::*;

    cfg_t       cfg_reg;
    quad_item_t push_item, head;
    logic       push, pop, queue_full, queue_empty;
    logic [COUNT_W-1:0] euler_number, single_count, triple_count, diagonal_count;

    // configuration registers; writes to indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold    <= RESET_THRESHOLD;
            cfg_reg.image_width  <= RESET_SIZE;
            cfg_reg.image_height <= RESET_SIZE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD:    cfg_reg.threshold    <= cfg_data[THR_W-1:0];
                CFG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data[SIZE_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front: binarize, line buffer, window classification
    enbq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .pixel      (s_axis_tdata),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    // decouples the pixel side from result back-pressure
    enbq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // back: totals and the result register
    enbq_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .empty          (queue_empty),
        .pop            (pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .euler_number   (euler_number),
        .single_count   (single_count),
        .triple_count   (triple_count),
        .diagonal_count (diagonal_count)
    );

    assign m_axis_tdata = {diagonal_count, triple_count, single_count, euler_number};

endmodule

`default_nettype wire

@@ sv/enbq_front.sv @@
// front end: binarizes pixels, keeps the one-bit line buffer and frame position,
// classifies each 2x2 window; depends on enbq_pkg
`default_nettype none

module enbq_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire enbq_pkg::cfg_t              cfg,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [enbq_pkg::PIXEL_W-1:0] pixel,
    output logic                             push,
    output enbq_pkg::quad_item_t             push_item,
    input  wire logic                        queue_full
);
    import enbq_pkg::*;

    logic              accept;
    logic [COL_W-1:0]  column_index_reg, column_index_next;
    logic [ROW_W-1:0]  row_index_reg, row_index_next;
    logic [SIZE_W-1:0] col_last, row_last;
    logic              col_end, row_end, fg_bit;

    logic              line_mem [MAX_WIDTH];

    // stage one registers
    logic s1_valid_reg, s1_valid_next;
    logic s1_bit_reg, s1_win_reg, s1_last_reg, s1_above_reg;

    // window neighbors in item order
    logic left_bit_reg, upper_left_reg;
    logic [2:0] ones;

    assign col_last = last_index(cfg.image_width, SIZE_W'(MAX_WIDTH));
    assign row_last = last_index(cfg.image_height, SIZE_W'(MAX_HEIGHT));
    assign col_end  = SIZE_W'(column_index_reg) >= col_last;
    assign row_end  = SIZE_W'(row_index_reg) >= row_last;
    assign fg_bit   = pixel >= cfg.threshold;

    assign push     = s1_valid_reg && !queue_full;
    assign in_ready = !s1_valid_reg || push;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        column_index_next = column_index_reg;
        row_index_next    = row_index_reg;
        if (accept)
        begin
            if (col_end)
            begin
                column_index_next = '0;
                row_index_next    = row_end ? '0 : row_index_reg + ROW_W'(1);
            end
            else
            begin
                column_index_next = column_index_reg + COL_W'(1);
            end
        end
        s1_valid_next = accept ? 1'b1 : (push ? 1'b0 : s1_valid_reg);
    end

    // read-first line buffer: old bit is the pixel above, new bit replaces it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[column_index_reg] <= fg_bit;
            s1_above_reg               <= line_mem[column_index_reg];
            s1_bit_reg                 <= fg_bit;
            s1_win_reg                 <= (row_index_reg != '0) && (column_index_reg != '0);
            s1_last_reg                <= col_end && row_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_index_reg <= '0;
            row_index_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            left_bit_reg     <= 1'b0;
            upper_left_reg   <= 1'b0;
        end
        else
        begin
            column_index_reg <= column_index_next;
            row_index_reg    <= row_index_next;
            s1_valid_reg     <= s1_valid_next;
            if (push)
            begin
                left_bit_reg   <= s1_bit_reg;
                upper_left_reg <= s1_above_reg;
            end
        end
    end

    // window: upper-left, upper-right (above), lower-left, lower-right (new)
    assign ones = 3'(upper_left_reg) + 3'(s1_above_reg) + 3'(left_bit_reg) + 3'(s1_bit_reg);

    always_comb
    begin
        push_item.last = s1_last_reg;
        push_item.kind = WIN_NONE;
        if (s1_win_reg)
        begin
            case (ones)
                3'd1:    push_item.kind = WIN_SINGLE;
                3'd3:    push_item.kind = WIN_TRIPLE;
                3'd2:
                begin
                    if ((upper_left_reg && s1_bit_reg) || (s1_above_reg && left_bit_reg))
                        push_item.kind = WIN_DIAG;
                end
                default: push_item.kind = WIN_NONE;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/enbq_queue.sv @@
// short fifo of classified windows between front and back
// depends on enbq_pkg
`default_nettype none

module enbq_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire enbq_pkg::quad_item_t push_item,
    input  wire logic                 pop,
    output enbq_pkg::quad_item_t      head,
    output logic                      full,
    output logic                      empty
);
    import enbq_pkg::*;

    quad_item_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + QPTR_W'(1);
        end
    end

endmodule

`default_nettype wire

@@ sv/enbq_back.sv @@
// back end: window totals, running euler sum and the result register
// depends on enbq_pkg
`default_nettype none

module enbq_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire enbq_pkg::quad_item_t         head,
    input  wire logic                         empty,
    output logic                              pop,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [enbq_pkg::COUNT_W-1:0]      euler_number,
    output logic [enbq_pkg::COUNT_W-1:0]      single_count,
    output logic [enbq_pkg::COUNT_W-1:0]      triple_count,
    output logic [enbq_pkg::COUNT_W-1:0]      diagonal_count
);
    import enbq_pkg::*;

    logic [COUNT_W-1:0] single_reg, single_next;
    logic [COUNT_W-1:0] triple_reg, triple_next;
    logic [COUNT_W-1:0] diag_reg, diag_next;
    // acc = single - triple + 2*diag; acc_p3 tracks acc + 3 for rounding toward zero
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [ACC_W-1:0]   acc_p3_reg, acc_p3_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_free, load;
    logic [COUNT_W-1:0] euler_reg, single_out_reg, triple_out_reg, diag_out_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign pop      = !empty && (!head.last || out_free);
    assign load     = pop && head.last;

    always_comb
    begin
        single_next = single_reg;
        triple_next = triple_reg;
        diag_next   = diag_reg;
        acc_next    = acc_reg;
        acc_p3_next = acc_p3_reg;
        if (pop)
        begin
            case (head.kind)
                WIN_SINGLE:
                begin
                    single_next = single_reg + COUNT_W'(1);
                    acc_next    = acc_reg + ACC_W'(1);
                    acc_p3_next = acc_p3_reg + ACC_W'(1);
                end
                WIN_TRIPLE:
                begin
                    triple_next = triple_reg + COUNT_W'(1);
                    acc_next    = acc_reg - ACC_W'(1);
                    acc_p3_next = acc_p3_reg - ACC_W'(1);
                end
                WIN_DIAG:
                begin
                    diag_next   = diag_reg + COUNT_W'(1);
                    acc_next    = acc_reg + ACC_W'(2);
                    acc_p3_next = acc_p3_reg + ACC_W'(2);
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
        out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            euler_reg      <= acc_next[ACC_W-1] ? acc_p3_next[ACC_W-1:2] : acc_next[ACC_W-1:2];
            single_out_reg <= single_next;
            triple_out_reg <= triple_next;
            diag_out_reg   <= diag_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_reg    <= '0;
            triple_reg    <= '0;
            diag_reg      <= '0;
            acc_reg       <= '0;
            acc_p3_reg    <= ACC_W'(3);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                single_reg <= '0;
                triple_reg <= '0;
                diag_reg   <= '0;
                acc_reg    <= '0;
                acc_p3_reg <= ACC_W'(3);
            end
            else
            begin
                single_reg <= single_next;
                triple_reg <= triple_next;
                diag_reg   <= diag_next;
                acc_reg    <= acc_next;
                acc_p3_reg <= acc_p3_next;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign euler_number   = euler_reg;
    assign single_count   = single_out_reg;
    assign triple_count   = triple_out_reg;
    assign diagonal_count = diag_out_reg;

endmodule

`default_nettype wire

@@ verif/euler_number_bit_quads_unit_test.sv @@
// testbench for euler_number_bit_quads_unit: pixel frames go in, one bit-quad result per frame
// comes out and is checked against an in-bench frame predictor
// depends on enbq_pkg and euler_number_bit_quads_unit only
module euler_number_bit_quads_unit_test;
    import enbq_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 8;      // extra wait after the last result so the pipeline empties
    localparam int REPORT_LIMIT = 10;

    // index with no register behind it, writes to it must change nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    // saturation points of the running totals and of the emitted counts
    localparam int TOTAL_LIMIT = 2**21 - 1;
    localparam int FIELD_LIMIT = 2**20 - 1;

    // how the pixels of one frame are drawn
    typedef enum int {
        PIX_UNIFORM,
        PIX_NEAR_THRESHOLD,
        PIX_SPARSE,
        PIX_DENSE
    } pixel_style_t;

    // same layout as m_axis_tdata, last field in the low bits
    typedef struct packed {
        logic [COUNT_W-1:0] diagonal_count;
        logic [COUNT_W-1:0] triple_count;
        logic [COUNT_W-1:0] single_count;
        logic [COUNT_W-1:0] euler_number;
    } frame_result_t;

    // dut ports, all inputs known from time zero
    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = '0;    // pixel[7:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // euler_number[19:0], single_count[39:20], triple_count[59:40], diagonal_count[79:60]
    logic [79:0]            m_axis_tdata;

    // predictor state: configuration, line buffer, window history, frame position, totals
    logic [THR_W-1:0]  model_threshold = RESET_THRESHOLD;
    logic [SIZE_W-1:0] model_width     = RESET_SIZE;
    logic [SIZE_W-1:0] model_height    = RESET_SIZE;
    bit                line_bits [MAX_WIDTH];
    bit                left_px;
    bit                upper_left_px;
    int unsigned       col_pos;
    int unsigned       row_pos;
    int unsigned       single_tot;
    int unsigned       triple_tot;
    int unsigned       diagonal_tot;

    // frame results predicted but not yet seen on the result stream
    frame_result_t pending_frames [$];

    // bookkeeping
    int error_count;
    int frames_checked;
    int pixels_sent;
    int cycle_count;
    int sender_idle_pct   = 36;
    int receiver_idle_pct = 76;

    euler_number_bit_quads_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 time unit clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog, bounds the whole run in clock cycles
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d frame results still outstanding",
                     cycle_count, pending_frames.size());
            $display("euler_number_bit_quads_unit_test: done, errors");
            $finish;
        end
    end

    // size registers saturate into 2..hi
    function automatic int clamped_dim(input logic [SIZE_W-1:0] v, input int hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return int'(v);
    endfunction

    // advance the frame predictor by one pixel; returns 1 when the pixel closes a frame
    function automatic bit count_bit_quads(input logic [PIXEL_W-1:0] px,
                                           output frame_result_t res);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned ones;
        bit          fg;
        bit          above;
        longint      euler;
        w     = clamped_dim(model_width, MAX_WIDTH);
        h     = clamped_dim(model_height, MAX_HEIGHT);
        fg    = (px >= model_threshold);
        col   = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
        above = line_bits[col];
        res   = '0;

        // only windows lying fully inside the frame are classified, no border padding
        if (row_pos >= 1 && col >= 1)
        begin
            // window: upper left, upper right (above), lower left, lower right (this pixel)
            ones = int'(upper_left_px) + int'(above) + int'(left_px) + int'(fg);
            if (ones == 1)
            begin
                if (single_tot < TOTAL_LIMIT)
                    single_tot++;
            end
            else if (ones == 3)
            begin
                if (triple_tot < TOTAL_LIMIT)
                    triple_tot++;
            end
            else if (ones == 2 && ((upper_left_px && fg) || (above && left_px)))
            begin
                if (diagonal_tot < TOTAL_LIMIT)
                    diagonal_tot++;
            end
        end

        upper_left_px  = above;
        left_px        = fg;
        line_bits[col] = fg;

        // row end uses >= so that a size shrunk mid-frame closes the row at once
        if (col + 1 >= w)
        begin
            col_pos = 0;
            if (row_pos + 1 >= h)
            begin
                // signed division truncates toward zero
                euler = (longint'(single_tot) - longint'(triple_tot)
                         + 2 * longint'(diagonal_tot)) / 4;
                res.euler_number   = euler[COUNT_W-1:0];
                res.single_count   = COUNT_W'((single_tot > FIELD_LIMIT) ? FIELD_LIMIT
                                                                         : single_tot);
                res.triple_count   = COUNT_W'((triple_tot > FIELD_LIMIT) ? FIELD_LIMIT
                                                                         : triple_tot);
                res.diagonal_count = COUNT_W'((diagonal_tot > FIELD_LIMIT) ? FIELD_LIMIT
                                                                           : diagonal_tot);
                single_tot   = 0;
                triple_tot   = 0;
                diagonal_tot = 0;
                row_pos      = 0;
                return 1'b1;
            end
            row_pos++;
        end
        else
            col_pos = col + 1;
        return 1'b0;
    endfunction

    // draw one pixel; some styles aim at the current threshold
    function automatic logic [PIXEL_W-1:0] pick_pixel(input pixel_style_t style);
        int v;
        case (style)
            PIX_NEAR_THRESHOLD: v = int'(model_threshold) + int'($urandom_range(2, 0)) - 1;
            PIX_SPARSE:         v = ($urandom_range(5, 0) == 0) ? 255 : 0;
            PIX_DENSE:          v = ($urandom_range(5, 0) == 0) ? 0 : 255;
            default:            v = int'($urandom_range(255, 0));
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[PIXEL_W-1:0];
    endfunction

    // one pixel transaction with random sender gaps; predicts on acceptance
    task automatic push_pixel(input logic [PIXEL_W-1:0] px);
        frame_result_t res;
        while ($urandom_range(99, 0) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pixels_sent++;
        if (count_bit_quads(px, res))
            pending_frames.insert(pending_frames.size(), res);
    endtask

    // 2x2 frame, first pixel (upper left) in the top byte
    task automatic send_quad(input logic [31:0] four);
        for (int i = 3; i >= 0; i--)
            push_pixel(four[i*8 +: 8]);
    endtask

    // whole frame at the current size
    task automatic send_frame(input pixel_style_t style);
        int n;
        n = clamped_dim(model_width, MAX_WIDTH) * clamped_dim(model_height, MAX_HEIGHT);
        repeat (n)
            push_pixel(pick_pixel(style));
    endtask

    // stop the stream, wait for every predicted result, then let the pipeline empty
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // back-to-back writes of all registers; optionally hits the unused index first
    task automatic load_setup(input logic [CFG_DATA_W-1:0] thr_word,
                              input logic [CFG_DATA_W-1:0] w,
                              input logic [CFG_DATA_W-1:0] h,
                              input bit                    poke_unused);
        if (poke_unused)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_UNUSED;
            cfg_data  <= '1;
            @(posedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= thr_word;
        @(posedge clk);
        model_threshold = thr_word[THR_W-1:0];
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        model_width = w;
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        model_height = h;
        cfg_we <= 1'b0;
    endtask

    // one 28x28 frame straight out of reset, pixels hugging the default threshold
    task automatic test_reset_defaults();
        send_frame(PIX_NEAR_THRESHOLD);
    endtask

    // each window class on a 2x2 frame, plus threshold extremes
    task automatic test_quad_patterns();
        drain_results();
        load_setup(11'd127, 11'd2, 11'd2, 1'b0);
        send_quad({8'd127, 8'd126, 8'd126, 8'd126});   // one set pixel, exactly at threshold
        send_quad({8'd0, 8'd255, 8'd255, 8'd255});     // three set, euler -1/4 truncates to 0
        send_quad({8'd255, 8'd0, 8'd0, 8'd255});       // main diagonal
        send_quad({8'd0, 8'd255, 8'd255, 8'd0});       // anti diagonal
        drain_results();
        // threshold 0 with junk in the upper data bits: everything is foreground
        load_setup(11'h700, 11'd2, 11'd2, 1'b0);
        send_quad({8'd0, 8'd0, 8'd0, 8'd255});
        drain_results();
        // threshold 255: only full white counts
        load_setup(11'd255, 11'd2, 11'd2, 1'b0);
        send_quad({8'd254, 8'd254, 8'd254, 8'd255});
    endtask

    // undersized registers, ignored index, and sizes shrunk in the middle of a frame
    task automatic test_size_changes();
        drain_results();
        load_setup(11'd127, 11'd1, 11'd0, 1'b1);        // both sizes saturate to 2
        send_quad({8'd255, 8'd255, 8'd0, 8'd255});
        drain_results();

        // width shrinks while the row in progress is at column 3: that row ends right there
        load_setup(11'd127, 11'd6, 11'd4, 1'b0);
        repeat (15)
            push_pixel(pick_pixel(PIX_UNIFORM));
        drain_results();
        load_setup(11'd127, 11'd4, 11'd4, 1'b0);
        repeat (5)
            push_pixel(pick_pixel(PIX_UNIFORM));
        drain_results();

        // height shrinks during row 2: that row becomes the last one
        load_setup(11'd127, 11'd4, 11'd5, 1'b0);
        repeat (10)
            push_pixel(pick_pixel(PIX_UNIFORM));
        drain_results();
        load_setup(11'd127, 11'd4, 11'd3, 1'b0);
        repeat (2)
            push_pixel(pick_pixel(PIX_UNIFORM));
        drain_results();
    endtask

    // over-range and maximum sizes: the frame runs past where a wrong limit would end it,
    // then the size is cut so that it closes early
    task automatic test_size_extremes();
        drain_results();
        // width 2047 saturates to 1024: 40 pixels stay inside row 0
        load_setup(11'($urandom_range(255, 0)), 11'd2047, 11'd2047, 1'b0);
        repeat (40)
            push_pixel(pick_pixel(PIX_UNIFORM));
        drain_results();
        // next pixel is past column 19 and closes row 0, a 20 pixel row 1 closes the frame
        load_setup(11'($urandom_range(255, 0)), 11'd20, 11'd2, 1'b0);
        repeat (21)
            push_pixel(pick_pixel(pixel_style_t'($urandom_range(3, 0))));
        drain_results();

        // height 2047 saturates to 1024: 40 rows of 2 stay inside the frame
        load_setup(11'($urandom_range(255, 0)), 11'd2, 11'd2047, 1'b0);
        repeat (80)
            push_pixel(pick_pixel(pixel_style_t'($urandom_range(3, 0))));
        drain_results();
        // row 40 becomes the last one
        load_setup(11'($urandom_range(255, 0)), 11'd2, 11'd41, 1'b0);
        repeat (2)
            push_pixel(pick_pixel(PIX_UNIFORM));
        drain_results();

        // exactly the maximum width and height, then cut to a 30 pixel row
        load_setup(11'($urandom_range(255, 0)), 11'd1024, 11'd1024, 1'b0);
        repeat (30)
            push_pixel(pick_pixel(PIX_UNIFORM));
        drain_results();
        load_setup(11'($urandom_range(255, 0)), 11'd30, 11'd2, 1'b0);
        repeat (31)
            push_pixel(pick_pixel(pixel_style_t'($urandom_range(3, 0))));
    endtask

    // whole frames with random size, threshold and pixel style, mostly small
    task automatic test_random_frames(input int pixel_goal);
        int                    first;
        int unsigned           pick;
        logic [SIZE_W-1:0]     w;
        logic [SIZE_W-1:0]     h;
        logic [CFG_DATA_W-1:0] thr_word;
        first = pixels_sent;
        while (pixels_sent - first < pixel_goal)
        begin
            if ($urandom_range(2, 0) == 0)
            begin
                pick = $urandom_range(9, 0);
                if (pick < 6)
                begin
                    w = SIZE_W'($urandom_range(8, 2));
                    h = SIZE_W'($urandom_range(8, 2));
                end
                else if (pick < 9)
                begin
                    w = SIZE_W'($urandom_range(40, 2));
                    h = SIZE_W'($urandom_range(10, 2));
                end
                else
                begin
                    // width below the legal range, height at most 3; values under 2 saturate up to 2
                    w = SIZE_W'($urandom_range(1, 0));
                    h = SIZE_W'($urandom_range(3, 0));
                end
                thr_word = CFG_DATA_W'($urandom_range(2047, 0));
                if ($urandom_range(4, 0) == 0)
                    thr_word[THR_W-1:0] = ($urandom_range(1, 0) == 1) ? 8'hFF : 8'h00;
                drain_results();
                load_setup(thr_word, w, h, 1'b0);
            end
            else if ($urandom_range(7, 0) == 0)
                drain_results();    // hold the stream until every frame result is back
            send_frame(pixel_style_t'($urandom_range(3, 0)));
        end
    endtask

    // result side: random backpressure, each result transaction checked against the oldest
    // predicted frame
    always @(posedge clk)
    begin
        frame_result_t want;
        frame_result_t got;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_frames.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("result transaction with no frame pending: %h", m_axis_tdata);
            end
            else
            begin
                want = pending_frames.pop_front();
                if (got.euler_number !== want.euler_number
                    || got.single_count !== want.single_count
                    || got.triple_count !== want.triple_count
                    || got.diagonal_count !== want.diagonal_count)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display({"frame %0d: euler exp %0d got %0d, single exp %0d got %0d,",
                                  " triple exp %0d got %0d, diagonal exp %0d got %0d"},
                                 frames_checked,
                                 $signed(want.euler_number), $signed(got.euler_number),
                                 want.single_count, got.single_count,
                                 want.triple_count, got.triple_count,
                                 want.diagonal_count, got.diagonal_count);
                end
                frames_checked++;
            end
        end
        m_axis_tready <= ($urandom_range(99, 0) >= receiver_idle_pct);
    end

    // test sequence
    initial
    begin
        // reset held from time zero, released once
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver heavily
        test_reset_defaults();
        test_quad_patterns();
        test_size_changes();
        test_random_frames(200);

        // swapped: sender idles heavily, receiver lightly
        sender_idle_pct   = 76;
        receiver_idle_pct = 36;
        test_size_extremes();
        test_random_frames(200);

        // full rate on both sides
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_frames(200);

        drain_results();
        $display("covered %0d pixels in %0d frames: every window class, thresholds 0..255,",
                 pixels_sent, frames_checked);
        $display("sizes from saturated minimum to saturated maximum, mid-frame shrinks and stalls");
        if (error_count == 0 && pending_frames.size() == 0)
            $display("euler_number_bit_quads_unit_test: done, clean");
        else
            $display("euler_number_bit_quads_unit_test: done, errors");
        $finish;
    end

endmodule
